// ===== sv/trfd_pkg.sv =====
// Shared constants, codes and controller/datapath handshake types for the touch report decoder.
`timescale 1ns / 1ps
`default_nettype none

package trfd_pkg;

    // Contact store depth default and register reset
    localparam int          MaxPointsDefault = 10;
    localparam logic [3:0]  MaxPointsReset   = 4'd10;

    // Status byte layout
    localparam int          ReadyBitPos = 7;
    localparam logic [7:0]  NibbleMask  = 8'h0F;

    // APB register map
    localparam int                   ApbAddrW      = 2;
    localparam int                   ApbDataW      = 32;
    localparam logic [ApbAddrW-1:0]  AddrMaxPoints = '0;

    // Byte offsets inside an 8-byte contact record
    localparam logic [2:0] PosSlot   = 3'd0;
    localparam logic [2:0] PosXLo    = 3'd1;
    localparam logic [2:0] PosXHi    = 3'd2;
    localparam logic [2:0] PosYLo    = 3'd3;
    localparam logic [2:0] PosYHi    = 3'd4;
    localparam logic [2:0] PosRecEnd = 3'd7;

    typedef enum logic [1:0] {
        EV_DOWN   = 2'd0,
        EV_UP     = 2'd1,
        EV_SYNC   = 2'd2,
        EV_REJECT = 2'd3
    } t_event_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_REJECT,
        ST_DOWN,
        ST_DOWN_CLOSE,
        ST_SCAN,
        ST_SYNC
    } t_state;

    typedef struct packed {
        logic        capture;
        logic        start_clear;
        logic        load_count;
        logic        set_active;
        logic        take_byte;
        logic        scan_clear;
        logic        scan_next;
        logic        commit;
        logic        emit;
        t_event_kind emit_kind;
        logic        emit_last;
    } t_dp_cmd;

    typedef struct packed {
        logic start;
        logic ready_bit;
        logic too_many;
        logic count_zero;
        logic active;
        logic rec_end;
        logic last_record;
        logic scan_done;
        logic held_present;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== sv/trfd_if.sv =====
// Valid/ready channel interfaces for report bytes in and contact events out.
`timescale 1ns / 1ps
`default_nettype none

interface trfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface trfd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [3:0]  slot;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        last_of_run;

    modport source (output valid, output event_kind, output slot, output pos_x,
                    output pos_y, output last_of_run, input ready);
    modport sink   (input valid, input event_kind, input slot, input pos_x,
                    input pos_y, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== sv/trfd_datapath.sv =====
// Datapath: byte capture, record assembly, slot stores, release scan and event output register.
`timescale 1ns / 1ps
`default_nettype none

module trfd_datapath #(
    parameter int MAX_POINTS = trfd_pkg::MaxPointsDefault
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_frame_start,
    input  wire logic [3:0]           i_max_points,
    input  wire trfd_pkg::t_dp_cmd    i_cmd,
    output trfd_pkg::t_dp_status      o_status,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [1:0]                o_event_kind,
    output logic [3:0]                o_slot,
    output logic [15:0]               o_pos_x,
    output logic [15:0]               o_pos_y,
    output logic                      o_last_of_run
);

    localparam int         IdxW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int         CntW   = $clog2(MAX_POINTS + 1);
    localparam logic [3:0] MaxPts = 4'(MAX_POINTS);

    // captured input transaction
    logic [7:0]      r_byte;
    logic            r_start;

    // frame state
    logic            r_frame_active;
    logic [CntW-1:0] r_frame_count;
    logic [CntW-1:0] r_held_count;
    logic [2:0]      r_pos_field;
    logic [IdxW-1:0] r_pos_rec;
    logic [3:0]      r_slot;
    logic [15:0]     r_x;
    logic [15:0]     r_y;
    logic [3:0]      r_held_slots  [MAX_POINTS];
    logic [3:0]      r_frame_slots [MAX_POINTS];
    logic [CntW-1:0] r_scan;

    // output register
    logic            r_out_valid;
    logic [1:0]      r_out_kind;
    logic [3:0]      r_out_slot;
    logic [15:0]     r_out_x;
    logic [15:0]     r_out_y;
    logic            r_out_last;

    logic [3:0]      cnt;
    logic [3:0]      lim;
    logic [3:0]      held_cur;
    logic            present;
    logic            close_now;

    assign cnt      = 4'(r_byte & trfd_pkg::NibbleMask);
    assign lim      = (i_max_points < MaxPts) ? i_max_points : MaxPts;
    assign held_cur = r_held_slots[r_scan[IdxW-1:0]];

    always_comb begin
        present = 1'b0;
        for (int j = 0; j < MAX_POINTS; j++) begin
            if ((CntW'(j) < r_frame_count) && (r_frame_slots[j] == held_cur)) begin
                present = 1'b1;
            end
        end
    end

    always_comb begin
        o_status.start        = r_start;
        o_status.ready_bit    = r_byte[trfd_pkg::ReadyBitPos];
        o_status.too_many     = cnt > lim;
        o_status.count_zero   = cnt == 4'd0;
        o_status.active       = r_frame_active;
        o_status.rec_end      = r_pos_field == trfd_pkg::PosRecEnd;
        o_status.last_record  = (CntW'(r_pos_rec) + CntW'(1)) >= r_frame_count;
        o_status.scan_done    = r_scan >= r_held_count;
        o_status.held_present = present;
        o_status.out_free     = !r_out_valid || i_out_ready;
    end

    assign close_now = i_cmd.take_byte && o_status.rec_end && o_status.last_record;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_active <= 1'b0;
            r_frame_count  <= '0;
            r_held_count   <= '0;
            r_pos_field    <= '0;
            r_pos_rec      <= '0;
            r_scan         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cmd.set_active) begin
                r_frame_active <= 1'b1;
            end else if (i_cmd.start_clear || close_now) begin
                r_frame_active <= 1'b0;
            end
            if (i_cmd.load_count) begin
                r_frame_count <= CntW'(cnt);
            end
            if (i_cmd.start_clear) begin
                r_pos_field <= '0;
                r_pos_rec   <= '0;
            end else if (i_cmd.take_byte) begin
                r_pos_field <= r_pos_field + 3'd1;
                if (o_status.rec_end) begin
                    r_pos_rec <= r_pos_rec + IdxW'(1);
                end
            end
            if (i_cmd.scan_clear) begin
                r_scan <= '0;
            end else if (i_cmd.scan_next) begin
                r_scan <= r_scan + CntW'(1);
            end
            if (i_cmd.commit) begin
                r_held_count <= r_frame_count;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_byte  <= i_data_byte;
            r_start <= i_frame_start;
        end
        if (i_cmd.take_byte) begin
            unique case (r_pos_field)
                trfd_pkg::PosSlot: r_slot      <= r_byte[3:0];
                trfd_pkg::PosXLo:  r_x[7:0]    <= r_byte;
                trfd_pkg::PosXHi:  r_x[15:8]   <= r_byte;
                trfd_pkg::PosYLo:  r_y[7:0]    <= r_byte;
                trfd_pkg::PosYHi:  r_y[15:8]   <= r_byte;
                default: ;
            endcase
            if (o_status.rec_end) begin
                r_frame_slots[r_pos_rec] <= r_slot;
            end
        end
        if (i_cmd.commit) begin
            for (int i = 0; i < MAX_POINTS; i++) begin
                r_held_slots[i] <= r_frame_slots[i];
            end
        end
        if (i_cmd.emit) begin
            r_out_kind <= i_cmd.emit_kind;
            r_out_last <= i_cmd.emit_last;
            case (i_cmd.emit_kind)
                trfd_pkg::EV_DOWN: begin
                    r_out_slot <= r_slot;
                    r_out_x    <= r_x;
                    r_out_y    <= r_y;
                end
                trfd_pkg::EV_UP: begin
                    r_out_slot <= held_cur;
                    r_out_x    <= '0;
                    r_out_y    <= '0;
                end
                default: begin
                    r_out_slot <= '0;
                    r_out_x    <= '0;
                    r_out_y    <= '0;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_kind  = r_out_kind;
    assign o_slot        = r_out_slot;
    assign o_pos_x       = r_out_x;
    assign o_pos_y       = r_out_y;
    assign o_last_of_run = r_out_last;

    a_frame_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_count <= CntW'(MAX_POINTS))
        else $error("frame count beyond store depth");

    a_held_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_count <= CntW'(MAX_POINTS))
        else $error("held count beyond store depth");

    a_active_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_active |-> (r_frame_count != '0))
        else $error("open frame with zero contacts");

    a_rec_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_active |-> (CntW'(r_pos_rec) < r_frame_count))
        else $error("record index past announced count");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("event emitted over an untaken event");

endmodule

`default_nettype wire

// ===== sv/trfd_ctrl.sv =====
// Controller state machine: sequences byte decode, event emission and the release scan.
`timescale 1ns / 1ps
`default_nettype none

module trfd_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire trfd_pkg::t_dp_status  i_status,
    output trfd_pkg::t_dp_cmd          o_cmd
);

    trfd_pkg::t_state r_state;
    trfd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= trfd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            trfd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = trfd_pkg::ST_DECODE;
                end
            end
            trfd_pkg::ST_DECODE: begin
                n_state = trfd_pkg::ST_IDLE;
                if (i_status.start) begin
                    o_cmd.start_clear = 1'b1;
                    if (!i_status.ready_bit) begin
                        n_state = trfd_pkg::ST_IDLE;
                    end else if (i_status.too_many) begin
                        n_state = trfd_pkg::ST_REJECT;
                    end else begin
                        o_cmd.load_count = 1'b1;
                        if (i_status.count_zero) begin
                            o_cmd.scan_clear = 1'b1;
                            n_state          = trfd_pkg::ST_SCAN;
                        end else begin
                            o_cmd.set_active = 1'b1;
                        end
                    end
                end else if (i_status.active) begin
                    o_cmd.take_byte = 1'b1;
                    if (i_status.rec_end) begin
                        n_state = i_status.last_record ? trfd_pkg::ST_DOWN_CLOSE
                                                       : trfd_pkg::ST_DOWN;
                    end
                end
            end
            trfd_pkg::ST_REJECT: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = trfd_pkg::EV_REJECT;
                    o_cmd.emit_last = 1'b1;
                    n_state         = trfd_pkg::ST_IDLE;
                end
            end
            trfd_pkg::ST_DOWN: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = trfd_pkg::EV_DOWN;
                    o_cmd.emit_last = 1'b1;
                    n_state         = trfd_pkg::ST_IDLE;
                end
            end
            trfd_pkg::ST_DOWN_CLOSE: begin
                if (i_status.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_kind  = trfd_pkg::EV_DOWN;
                    o_cmd.scan_clear = 1'b1;
                    n_state          = trfd_pkg::ST_SCAN;
                end
            end
            trfd_pkg::ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = trfd_pkg::ST_SYNC;
                end else if (i_status.held_present) begin
                    o_cmd.scan_next = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = trfd_pkg::EV_UP;
                    o_cmd.scan_next = 1'b1;
                end
            end
            trfd_pkg::ST_SYNC: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = trfd_pkg::EV_SYNC;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.commit    = 1'b1;
                    n_state         = trfd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = trfd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/touch_report_frame_decoder.sv =====
// Top level of the touch report frame decoder: channels, APB register and unit hookup.
// Sequencing: a byte is decoded in the cycle after its transaction; a record's last byte
//   then waits in DOWN or DOWN_CLOSE until the output register is free to take its event.
// Throughput: a byte is taken only in IDLE, after the last one's decode and event; a frame close
//   adds the release scan (one compare pass per cycle, unless an UP event waits) and SYNC.
// Reset (i_rst_n low, synchronous): no frame open, held and frame counts zero,
//   max_points = 10, output register empty. Slot stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module touch_report_frame_decoder #(
    parameter int MAX_POINTS = trfd_pkg::MaxPointsDefault
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    trfd_in_if.sink                             i_byte_ch,
    trfd_out_if.source                          o_event_ch,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [trfd_pkg::ApbAddrW-1:0]  paddr,
    input  wire logic [trfd_pkg::ApbDataW-1:0]  pwdata,
    output logic [trfd_pkg::ApbDataW-1:0]       prdata,
    output logic                                pready
);

    // max_points register: caps the contact count a frame may announce
    logic [3:0]           r_max_points;
    logic                 cfg_write;

    trfd_pkg::t_dp_cmd    cmd;
    trfd_pkg::t_dp_status status;

    // No wait states; a write lands on the access-phase edge.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr == trfd_pkg::AddrMaxPoints);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_points <= trfd_pkg::MaxPointsReset;
        end else if (cfg_write) begin
            r_max_points <= pwdata[3:0];
        end
    end

    // Unaligned or unmapped addresses read as zero
    assign prdata = (paddr == trfd_pkg::AddrMaxPoints)
                    ? {{(trfd_pkg::ApbDataW - 4){1'b0}}, r_max_points}
                    : '0;

    // Controller: takes one byte transaction at a time, walks decode, emit and scan steps
    trfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_byte_ch.valid),
        .o_in_ready (i_byte_ch.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath: record assembly, slot stores and the output register. The output
    // register decouples the sides, so the next byte is taken while an event waits.
    trfd_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_byte_ch.data_byte),
        .i_frame_start (i_byte_ch.frame_start),
        .i_max_points  (r_max_points),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_ready   (o_event_ch.ready),
        .o_out_valid   (o_event_ch.valid),
        .o_event_kind  (o_event_ch.event_kind),
        .o_slot        (o_event_ch.slot),
        .o_pos_x       (o_event_ch.pos_x),
        .o_pos_y       (o_event_ch.pos_y),
        .o_last_of_run (o_event_ch.last_of_run)
    );

endmodule

`default_nettype wire
